[rtl/hrp_pkg.sv]
// hrp_pkg: types, character constants and helper functions for the HTTP
// response header parser. Used by hrp_core, hrp_cfg_regs and the top level.
// No dependencies.
package hrp_pkg;

  localparam int unsigned MllW = 13;
  localparam int unsigned AccW = 32;

  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_CONNECT = 2'd1,
    OP_CLOSE   = 2'd2,
    OP_FAIL    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HEADERS  = 3'd1,
    PH_BODY     = 3'd2,
    PH_COMPLETE = 3'd3,
    PH_FAILED   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_OTHER  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_DONE   = 2'd2
  } num_stage_e;

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;

  localparam logic [3:0] StatusLen = 4'd5;
  localparam logic [3:0] LengthLen = 4'd15;

  localparam logic [AccW-1:0] AccSat = 32'h8000_0000;
  localparam logic [AccW-1:0] PosMax = 32'h7FFF_FFFF;

  typedef struct packed {
    num_stage_e      stage;
    logic            neg;
    logic [AccW-1:0] acc;
  } num_t;

  typedef struct packed {
    logic [MllW-1:0] count;
    logic [3:0]      pos;
    kind_e           kind;
    logic            space;
    num_t            num;
  } line_t;

  localparam line_t LineClear = '{
    count: '0, pos: '0, kind: KIND_STATUS, space: 1'b0,
    num: '{stage: NUM_SKIP, neg: 1'b0, acc: '0}
  };

  typedef struct packed {
    phase_e      phase;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        headers_done;
    logic        line_too_long;
    logic [31:0] response_code;
    logic [31:0] content_length;
  } res_t;

  // "HTTP/"
  function automatic logic [7:0] status_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h48;
      4'd1:    ch = 8'h54;
      4'd2:    ch = 8'h54;
      4'd3:    ch = 8'h50;
      4'd4:    ch = 8'h2F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "Content-Length:"
  function automatic logic [7:0] length_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h43;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h6E;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2D;
      4'd8:    ch = 8'h4C;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6E;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      4'd14:   ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // One step of atoi: whitespace skip, sign, then digits saturating at 2^31.
  function automatic num_t feed_number(input num_t n, input logic [7:0] c);
    num_t        r;
    logic        digit;
    logic        ws;
    logic        take;
    logic [35:0] t;
    r     = n;
    digit = (c >= Ch0) && (c <= Ch9);
    ws    = (c == ChSpace) || (c == ChTab) || (c == ChVt) || (c == ChFf);
    take  = 1'b0;
    case (n.stage)
      NUM_SKIP: begin
        if (ws) begin
          r.stage = NUM_SKIP;
        end else if (c == ChPlus) begin
          r.stage = NUM_DIGITS;
        end else if (c == ChMinus) begin
          r.stage = NUM_DIGITS;
          r.neg   = 1'b1;
        end else if (!digit) begin
          r.stage = NUM_DONE;
        end else begin
          r.stage = NUM_DIGITS;
          take    = 1'b1;
        end
      end
      NUM_DIGITS: begin
        if (!digit) begin
          r.stage = NUM_DONE;
        end else begin
          take = 1'b1;
        end
      end
      default: r.stage = n.stage;
    endcase
    t = ({4'b0, n.acc} << 3) + ({4'b0, n.acc} << 1) + {32'b0, c[3:0]};
    if (take) begin
      r.acc = (t > {4'b0, AccSat}) ? AccSat : t[AccW-1:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] number_value(input num_t n);
    logic [31:0] v;
    if (n.neg) begin
      v = (n.acc >= AccSat) ? AccSat : (32'd0 - n.acc);
    end else begin
      v = (n.acc > PosMax) ? PosMax : n.acc;
    end
    return v;
  endfunction

endpackage

[rtl/hrp_cfg_regs.sv]
// hrp_cfg_regs: APB register file holding the header line length limit,
// clamped to the line buffer size. Depends on hrp_pkg.
module hrp_cfg_regs #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output logic [hrp_pkg::MllW-1:0] limit_o
);

  localparam int unsigned MllMax = (1 << hrp_pkg::MllW) - 1;
  localparam logic [hrp_pkg::MllW-1:0] BufCap =
    (BUFFER_BYTES > MllMax) ? hrp_pkg::MllW'(MllMax) : hrp_pkg::MllW'(BUFFER_BYTES);
  localparam logic [hrp_pkg::MllW-1:0] MllReset = hrp_pkg::MllW'(4096);

  logic [hrp_pkg::MllW-1:0] mll_q;
  logic                     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mll_q <= MllReset;
    end else if (wr_en) begin
      mll_q <= pwdata[hrp_pkg::MllW-1:0];
    end
  end

  assign prdata  = (paddr[2] == 1'b0) ? {{(32 - hrp_pkg::MllW){1'b0}}, mll_q} : 32'd0;
  assign limit_o = (mll_q > BufCap) ? BufCap : mll_q;

endmodule

[rtl/hrp_core.sv]
// hrp_core: parser state (phase, line matcher, number reader, parsed values)
// and the update per event, registered when fire_i is high. Depends on hrp_pkg.
module hrp_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  hrp_pkg::opcode_e         op_i,
  input  logic [7:0]               byte_i,
  input  logic [hrp_pkg::MllW-1:0] limit_i,
  output hrp_pkg::res_t            res_o
);

  hrp_pkg::phase_e phase_q, phase_d;
  hrp_pkg::line_t  line_q, line_d;
  logic [31:0]     status_q, status_d;
  logic [31:0]     length_q, length_d;

  hrp_pkg::line_t           lc;
  logic [hrp_pkg::MllW-1:0] count_inc;

  always_comb begin
    phase_d  = phase_q;
    line_d   = line_q;
    status_d = status_q;
    length_d = length_q;
    res_o.body_valid    = 1'b0;
    res_o.body_byte     = 8'd0;
    res_o.headers_done  = 1'b0;
    res_o.line_too_long = 1'b0;

    count_inc = line_q.count + 1'b1;
    lc        = line_q;
    lc.count  = count_inc;
    if (byte_i != hrp_pkg::ChCr) begin
      if (line_q.kind == hrp_pkg::KIND_STATUS && line_q.pos == 4'd0) begin
        if (byte_i == hrp_pkg::status_char(4'd0)) begin
          lc.pos = 4'd1;
        end else if (byte_i == hrp_pkg::length_char(4'd0)) begin
          lc.kind = hrp_pkg::KIND_LENGTH;
          lc.pos  = 4'd1;
        end else begin
          lc.kind = hrp_pkg::KIND_OTHER;
        end
      end else if (line_q.kind == hrp_pkg::KIND_STATUS) begin
        if (line_q.pos < hrp_pkg::StatusLen) begin
          if (byte_i == hrp_pkg::status_char(line_q.pos)) begin
            lc.pos = line_q.pos + 4'd1;
          end else begin
            lc.kind = hrp_pkg::KIND_OTHER;
          end
        end else if (!line_q.space) begin
          lc.space = (byte_i == hrp_pkg::ChSpace);
        end else begin
          lc.num = hrp_pkg::feed_number(line_q.num, byte_i);
        end
      end else if (line_q.kind == hrp_pkg::KIND_LENGTH) begin
        if (line_q.pos < hrp_pkg::LengthLen) begin
          if (byte_i == hrp_pkg::length_char(line_q.pos)) begin
            lc.pos = line_q.pos + 4'd1;
          end else begin
            lc.kind = hrp_pkg::KIND_OTHER;
          end
        end else begin
          lc.num = hrp_pkg::feed_number(line_q.num, byte_i);
        end
      end
    end

    case (op_i)
      hrp_pkg::OP_CONNECT: begin
        phase_d = hrp_pkg::PH_HEADERS;
        line_d  = hrp_pkg::LineClear;
      end
      hrp_pkg::OP_CLOSE: phase_d = hrp_pkg::PH_COMPLETE;
      hrp_pkg::OP_FAIL:  phase_d = hrp_pkg::PH_FAILED;
      default: begin
        if (phase_q == hrp_pkg::PH_BODY) begin
          res_o.body_valid = 1'b1;
          res_o.body_byte  = byte_i;
        end else if (phase_q == hrp_pkg::PH_HEADERS) begin
          if (byte_i == hrp_pkg::ChLf) begin
            if (line_q.kind == hrp_pkg::KIND_STATUS && line_q.pos == 4'd0) begin
              res_o.headers_done = 1'b1;
              phase_d            = hrp_pkg::PH_BODY;
            end else if (line_q.kind == hrp_pkg::KIND_LENGTH &&
                         line_q.pos == hrp_pkg::LengthLen) begin
              length_d = hrp_pkg::number_value(line_q.num);
            end else if (line_q.kind == hrp_pkg::KIND_STATUS &&
                         line_q.pos == hrp_pkg::StatusLen && line_q.space) begin
              status_d = hrp_pkg::number_value(line_q.num);
            end
            line_d = hrp_pkg::LineClear;
          end else if (count_inc >= limit_i) begin
            res_o.line_too_long = 1'b1;
            phase_d             = hrp_pkg::PH_FAILED;
            line_d              = hrp_pkg::LineClear;
          end else begin
            line_d = lc;
          end
        end
      end
    endcase

    res_o.phase          = phase_d;
    res_o.response_code  = status_d;
    res_o.content_length = length_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= hrp_pkg::PH_IDLE;
      line_q   <= hrp_pkg::LineClear;
      status_q <= 32'd0;
      length_q <= 32'd0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      line_q   <= line_d;
      status_q <= status_d;
      length_q <= length_d;
    end
  end

endmodule

[rtl/http_response_header_parser.sv]
// http_response_header_parser: top level with input register, parser core,
// result register and APB configuration. Depends on hrp_pkg, hrp_core and
// hrp_cfg_regs.
//
//   channel   direction  handshake                 payload
//   s_axis    in         tvalid/tready             tuser opcode, tdata data_byte
//   m_axis    out        tvalid/tready             tuser body_valid, tdata result
//   apb       in/out     psel/penable/pready       max_line_length at 0x0
//
// One transaction per clock sustained while m_axis accepts every result; the
// result reaches m_axis through the input register, then the result register.
// The core updates its state in the same cycle the item leaves the input
// register. A stall on m_axis holds the result register, then the input
// register, then drops s_axis_tready. Reset clears control state, the limit
// to 4096 and both parsed values to zero.
module http_response_header_parser #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] phase, [10:3] body_byte, [11] headers_done, [12] line_too_long,
  // [44:13] response_code, [76:45] content_length, [79:77] zero
  output logic [79:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser,   // [0] body_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                     in_valid_q;
  hrp_pkg::opcode_e         in_op_q;
  logic [7:0]               in_byte_q;
  logic                     out_valid_q;
  hrp_pkg::res_t            out_res_q;
  hrp_pkg::res_t            core_res;
  logic [hrp_pkg::MllW-1:0] limit;
  logic                     out_free;
  logic                     advance;
  logic                     in_take;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  hrp_cfg_regs #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  hrp_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .op_i    (in_op_q),
    .byte_i  (in_byte_q),
    .limit_i (limit),
    .res_o   (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q   <= hrp_pkg::opcode_e'(s_axis_tuser);
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.body_valid;
  assign m_axis_tdata  = {3'b000, out_res_q.content_length, out_res_q.response_code,
                          out_res_q.line_too_long, out_res_q.headers_done,
                          out_res_q.body_byte, out_res_q.phase};

endmodule

[rtl/hrp_checker.sv]
// hrp_checker: port-level assertions for http_response_header_parser, bound
// to the top level below. Depends on hrp_pkg.
module hrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic [2:0] ph;
  assign ph = m_axis_tdata[2:0];

  // body bytes only come out in the body phase
  a_body_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> ph == hrp_pkg::PH_BODY)
    else $error("body byte outside body phase");

  // end of headers moves to body and carries no body byte
  a_hdone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11] |-> ph == hrp_pkg::PH_BODY && !m_axis_tuser[0])
    else $error("headers_done with wrong phase or body byte");

  // overflow always fails the transfer
  a_too_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12] |-> ph == hrp_pkg::PH_FAILED && !m_axis_tdata[11])
    else $error("line_too_long without failed phase");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind http_response_header_parser hrp_checker u_hrp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[dv/hrp_result_checker.sv]
// hrp_result_checker: watches the stream and APB ports of the HTTP response
// header parser, predicts every result transaction and compares it field by field.
// It also checks the limit readback over APB. Depends on hrp_pkg.
module hrp_result_checker #(
  parameter int unsigned BufferBytes = 4096,
  parameter logic [2:0]  LimitAddr   = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [79:0] m_tdata_i,
  input  logic [0:0]  m_tuser_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  input  logic        pready_i,
  output int          fails_o,
  output int          pending_o,
  output int          items_o,
  output int          results_o,
  output int          body_bytes_o,
  output int          header_ends_o,
  output int          overflows_o
);

  localparam logic [8*5-1:0]  StatusText = "HTTP/";
  localparam logic [8*15-1:0] LengthText = "Content-Length:";

  logic [hrp_pkg::MllW-1:0] limit_q;
  hrp_pkg::phase_e          phase_q;
  logic [hrp_pkg::MllW-1:0] count_q;
  logic [3:0]               pos_q;
  hrp_pkg::kind_e           kind_q;
  logic                     space_q;
  hrp_pkg::num_stage_e      stage_q;
  logic                     neg_q;
  logic [31:0]              acc_q;
  logic [31:0]              status_q;
  logic [31:0]              length_q;
  hrp_pkg::res_t            predicted_results[$];
  int                       fails, items, results, body_bytes, header_ends, overflows;

  task automatic clear_line();
    count_q = '0;
    pos_q   = '0;
    kind_q  = hrp_pkg::KIND_STATUS;
    space_q = 1'b0;
    stage_q = hrp_pkg::NUM_SKIP;
    neg_q   = 1'b0;
    acc_q   = '0;
  endtask

  task automatic atoi_step(input logic [7:0] c);
    logic        is_digit;
    logic        is_space;
    logic        take;
    logic [35:0] prod;
    is_digit = (c >= "0") && (c <= "9");
    is_space = (c == hrp_pkg::ChSpace) || (c == hrp_pkg::ChTab) ||
               (c == hrp_pkg::ChVt) || (c == hrp_pkg::ChFf);
    take     = 1'b0;
    case (stage_q)
      hrp_pkg::NUM_SKIP: begin
        if (c == "+") begin
          stage_q = hrp_pkg::NUM_DIGITS;
        end else if (c == "-") begin
          stage_q = hrp_pkg::NUM_DIGITS;
          neg_q   = 1'b1;
        end else if (is_digit) begin
          stage_q = hrp_pkg::NUM_DIGITS;
          take    = 1'b1;
        end else if (!is_space) begin
          stage_q = hrp_pkg::NUM_DONE;
        end
      end
      hrp_pkg::NUM_DIGITS: begin
        if (is_digit) begin
          take = 1'b1;
        end else begin
          stage_q = hrp_pkg::NUM_DONE;
        end
      end
      default: ;
    endcase
    if (take) begin
      prod  = {4'd0, acc_q} * 36'd10 + {32'd0, c[3:0]};
      acc_q = (prod > 36'h0_8000_0000) ? 32'h8000_0000 : prod[31:0];
    end
  endtask

  function automatic logic [31:0] atoi_value();
    if (neg_q) begin
      return (acc_q >= 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - acc_q);
    end
    return (acc_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc_q;
  endfunction

  task automatic header_char(input logic [7:0] c);
    if (kind_q == hrp_pkg::KIND_STATUS && pos_q == 0) begin
      if (c == StatusText[39:32]) begin
        pos_q = 4'd1;
      end else if (c == LengthText[119:112]) begin
        kind_q = hrp_pkg::KIND_LENGTH;
        pos_q  = 4'd1;
      end else begin
        kind_q = hrp_pkg::KIND_OTHER;
      end
    end else if (kind_q == hrp_pkg::KIND_STATUS) begin
      if (pos_q < hrp_pkg::StatusLen) begin
        if (c == StatusText[8*(4-int'(pos_q)) +: 8]) begin
          pos_q++;
        end else begin
          kind_q = hrp_pkg::KIND_OTHER;
        end
      end else if (!space_q) begin
        space_q = (c == hrp_pkg::ChSpace);
      end else begin
        atoi_step(c);
      end
    end else if (kind_q == hrp_pkg::KIND_LENGTH) begin
      if (pos_q < hrp_pkg::LengthLen) begin
        if (c == LengthText[8*(14-int'(pos_q)) +: 8]) begin
          pos_q++;
        end else begin
          kind_q = hrp_pkg::KIND_OTHER;
        end
      end else begin
        atoi_step(c);
      end
    end
  endtask

  task automatic parse_event(input logic [1:0] op, input logic [7:0] b,
                             output hrp_pkg::res_t r);
    int unsigned cap;
    r   = '0;
    cap = (limit_q > BufferBytes) ? BufferBytes : limit_q;
    case (hrp_pkg::opcode_e'(op))
      hrp_pkg::OP_CONNECT: begin
        phase_q = hrp_pkg::PH_HEADERS;
        clear_line();
      end
      hrp_pkg::OP_CLOSE: phase_q = hrp_pkg::PH_COMPLETE;
      hrp_pkg::OP_FAIL:  phase_q = hrp_pkg::PH_FAILED;
      default: begin
        if (phase_q == hrp_pkg::PH_BODY) begin
          r.body_valid = 1'b1;
          r.body_byte  = b;
        end else if (phase_q == hrp_pkg::PH_HEADERS) begin
          if (b == hrp_pkg::ChLf) begin
            if (kind_q == hrp_pkg::KIND_STATUS && pos_q == 0) begin
              r.headers_done = 1'b1;
              phase_q        = hrp_pkg::PH_BODY;
            end else if (kind_q == hrp_pkg::KIND_LENGTH && pos_q == hrp_pkg::LengthLen) begin
              length_q = atoi_value();
            end else if (kind_q == hrp_pkg::KIND_STATUS && pos_q == hrp_pkg::StatusLen &&
                         space_q) begin
              status_q = atoi_value();
            end
            clear_line();
          end else begin
            count_q++;
            if (b != hrp_pkg::ChCr) begin
              header_char(b);
            end
            if (count_q >= cap) begin
              r.line_too_long = 1'b1;
              phase_q         = hrp_pkg::PH_FAILED;
              clear_line();
            end
          end
        end
      end
    endcase
    r.phase          = phase_q;
    r.response_code  = status_q;
    r.content_length = length_q;
  endtask

  function automatic string describe(input hrp_pkg::res_t r);
    return $sformatf("phase=%0d body=%0b/%02h done=%0b long=%0b code=%0d length=%0d",
                     r.phase, r.body_valid, r.body_byte, r.headers_done, r.line_too_long,
                     $signed(r.response_code), $signed(r.content_length));
  endfunction

  task automatic report(input string msg);
    fails++;
    if (fails <= 10) begin
      $display("%t mismatch: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    hrp_pkg::res_t want;
    hrp_pkg::res_t got;
    if (!rst_ni) begin
      limit_q  = 13'd4096;
      phase_q  = hrp_pkg::PH_IDLE;
      clear_line();
      status_q = '0;
      length_q = '0;
      predicted_results.delete();
      fails = 0;
      items = 0;
      results = 0;
      body_bytes = 0;
      header_ends = 0;
      overflows = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == LimitAddr) begin
        if (pwrite_i) begin
          limit_q = pwdata_i[hrp_pkg::MllW-1:0];
        end else if (prdata_i !== 32'(limit_q)) begin
          report($sformatf("limit readback expected %0d got %0d", limit_q, prdata_i));
        end
      end
      // older expectation leaves before this edge's input is predicted
      if (m_tvalid_i && m_tready_i) begin
        got.phase          = hrp_pkg::phase_e'(m_tdata_i[2:0]);
        got.body_valid     = m_tuser_i[0];
        got.body_byte      = m_tdata_i[10:3];
        got.headers_done   = m_tdata_i[11];
        got.line_too_long  = m_tdata_i[12];
        got.response_code  = m_tdata_i[44:13];
        got.content_length = m_tdata_i[76:45];
        results++;
        if (predicted_results.size() == 0) begin
          report($sformatf("unexpected result %s", describe(got)));
        end else begin
          want = predicted_results.pop_front();
          body_bytes  += want.body_valid;
          header_ends += want.headers_done;
          overflows   += want.line_too_long;
          if (got !== want || m_tdata_i[79:77] !== 3'b000) begin
            report($sformatf("expected %s, got %s pad=%0b", describe(want), describe(got),
                             m_tdata_i[79:77]));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        parse_event(s_tuser_i, s_tdata_i, want);
        predicted_results.push_back(want);
        items++;
      end
    end
    fails_o       <= fails;
    pending_o     <= predicted_results.size();
    items_o       <= items;
    results_o     <= results;
    body_bytes_o  <= body_bytes;
    header_ends_o <= header_ends;
    overflows_o   <= overflows;
  end

endmodule

[dv/testbench.sv]
// testbench: drives header, body and connection-event streams with random idling
// into http_response_header_parser under several line limits and gives the verdict.
// Depends on hrp_pkg, the parser RTL and hrp_result_checker.
module testbench;

  localparam int unsigned BufferBytes = 256;
  localparam logic [2:0]  LimitAddr   = 3'd0;
  localparam int unsigned LongStall   = 300;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic [1:0]  s_axis_tuser  = hrp_pkg::OP_DATA;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = LimitAddr;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int fails, pending, items, results, body_bytes, header_ends, overflows;
  int sent_items;
  int limit_settings;
  bit calm;
  bit hold_request;
  logic [7:0] line_buf[$];

  always #4 clk = ~clk;

  http_response_header_parser #(
    .BUFFER_BYTES(BufferBytes)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  hrp_result_checker #(
    .BufferBytes(BufferBytes),
    .LimitAddr  (LimitAddr)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fails_o      (fails),
    .pending_o    (pending),
    .items_o      (items),
    .results_o    (results),
    .body_bytes_o (body_bytes),
    .header_ends_o(header_ends),
    .overflows_o  (overflows)
  );

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (stall_left == 0 && hold_request) begin
        hold_request = 1'b0;
        stall_left   = LongStall;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == hrp_pkg::ChLf);
    return b;
  endfunction

  task automatic send_item(input hrp_pkg::opcode_e op, input logic [7:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sent_items++;
  endtask

  // sends line_buf, with a stray random item (event or data byte) now and then
  task automatic send_line();
    foreach (line_buf[i]) begin
      if (!calm && $urandom_range(0, 63) == 0) begin
        send_item(hrp_pkg::opcode_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
      send_item(hrp_pkg::OP_DATA, line_buf[i]);
    end
    line_buf.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      line_buf.push_back(s[i]);
    end
  endtask

  task automatic add_number();
    int digits;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       line_buf.push_back(hrp_pkg::ChSpace);
        1:       line_buf.push_back(hrp_pkg::ChTab);
        2:       line_buf.push_back(hrp_pkg::ChVt);
        default: line_buf.push_back(hrp_pkg::ChFf);
      endcase
    end
    case ($urandom_range(0, 3))
      0:       line_buf.push_back("+");
      1:       line_buf.push_back("-");
      default: ;
    endcase
    digits = 0;
    case ($urandom_range(0, 7))
      0:       add_text("2147483647");
      1:       add_text("2147483648");
      2:       digits = $urandom_range(10, 13);
      default: digits = $urandom_range(0, 4);
    endcase
    repeat (digits) line_buf.push_back(8'("0" + $urandom_range(0, 9)));
    if ($urandom_range(0, 1)) begin
      line_buf.push_back(any_but_lf());
    end
  endtask

  task automatic send_header_line();
    string pre;
    case ($urandom_range(0, 7))
      0, 1: begin
        add_text($urandom_range(0, 1) ? "HTTP/1.0 " : "HTTP/ ");
        add_number();
        if ($urandom_range(0, 1)) add_text(" OK");
      end
      2, 3: begin
        add_text("Content-Length:");
        add_number();
      end
      4: add_text("HTTP/1.1");
      5: begin
        pre = $urandom_range(0, 1) ? "Content-Length:" : "HTTP/";
        add_text(pre.substr(0, $urandom_range(0, pre.len() - 2)));
        line_buf.push_back(any_but_lf());
        add_text(" 77");
      end
      default: begin
        repeat ($urandom_range(1, 24)) line_buf.push_back(any_but_lf());
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      line_buf.insert($urandom_range(0, line_buf.size()), hrp_pkg::ChCr);
    end
    if ($urandom_range(0, 1)) line_buf.push_back(hrp_pkg::ChCr);
    line_buf.push_back(hrp_pkg::ChLf);
    send_line();
  endtask

  task automatic send_transfer();
    send_item(hrp_pkg::OP_CONNECT, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 4)) send_header_line();
    if ($urandom_range(0, 7) != 0) begin
      if ($urandom_range(0, 1)) line_buf.push_back(hrp_pkg::ChCr);
      line_buf.push_back(hrp_pkg::ChLf);
      repeat ($urandom_range(0, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
      send_line();
    end
    case ($urandom_range(0, 3))
      0:       send_item(hrp_pkg::OP_CLOSE, 8'($urandom_range(0, 255)));
      1:       send_item(hrp_pkg::OP_FAIL, 8'($urandom_range(0, 255)));
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      send_item(hrp_pkg::OP_DATA, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int target);
    int start;
    start = sent_items;
    while (sent_items - start < target) send_transfer();
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= LimitAddr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limit(input int unsigned value);
    wait_idle();
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
    limit_settings++;
  endtask

  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sent_items     = 0;
    limit_settings = 1;
    calm           = 1'b0;
    hold_request   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    apb_access(1'b0, '0);

    // events and data outside a transfer, then one short response
    send_item(hrp_pkg::OP_DATA, "A");
    send_item(hrp_pkg::OP_CLOSE, 8'hFF);
    send_item(hrp_pkg::OP_DATA, 8'h00);
    send_item(hrp_pkg::OP_FAIL, 8'h00);
    send_item(hrp_pkg::OP_DATA, hrp_pkg::ChLf);
    send_item(hrp_pkg::OP_CONNECT, 8'hFF);
    line_buf.push_back(hrp_pkg::ChCr);
    add_text("HTTP/1 -7");
    line_buf.push_back(hrp_pkg::ChCr);
    add_text("\nHTTP/1\nContent-Length:99999999999\n");
    line_buf.push_back(hrp_pkg::ChCr);
    line_buf.push_back(hrp_pkg::ChLf);
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    line_buf.push_back(hrp_pkg::ChLf);
    send_line();
    send_item(hrp_pkg::OP_CONNECT, 8'h00);
    send_item(hrp_pkg::OP_CLOSE, 8'h00);

    set_limit(1);
    run_random(80);

    // a line of exactly the buffer size
    set_limit(4096);
    send_item(hrp_pkg::OP_CONNECT, 8'h00);
    repeat (BufferBytes) line_buf.push_back(any_but_lf());
    send_line();
    send_item(hrp_pkg::OP_DATA, "x");

    set_limit($urandom_range(12, 40));
    hold_request = 1'b1;
    run_random(220);

    set_limit($urandom_range(41, 4096));
    run_random(200);

    calm = 1'b1;
    set_limit($urandom_range(20, 60));
    run_random(180);

    wait_idle();
    $display("Sent %0d input transactions, checked %0d results over %0d limit settings.",
             items, results, limit_settings);
    $display("Body bytes %0d, header ends %0d, overlong lines %0d.",
             body_bytes, header_ends, overflows);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
